// ===== rtl/dlst_pkg.sv =====
// Package for the delta-list sleep timer: command codes, register indexes, sizes, defaults.
// No dependencies.
`timescale 1ns / 1ps
package dlst_pkg;
	localparam int NUM_PROCS_DEF = 16;
	localparam int MAX_WAKE      = 16;
	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic       REG_QUANTUM = 1'b0;
	localparam logic       REG_TPS     = 1'b1;
	localparam logic [7:0]  QUANTUM_RST = 8'd2;
	localparam logic [15:0] TPS_RST     = 16'd1000;
endpackage

// ===== rtl/dlst_cell.sv =====
// One cell of the sorted sleep chain: holds an id and its absolute remaining delay.
// Depends on dlst_pkg.
`timescale 1ns / 1ps
module dlst_cell import dlst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        shift_up,   // take neighbour below (remove/wake compaction)
	input  logic        shift_dn,   // take neighbour above (insert opening)
	input  logic        load,       // take new entry
	input  logic        dec,        // tick: key minus one
	input  logic        up_vld,
	input  logic [7:0]  up_id,
	input  logic [32:0] up_key,
	input  logic        dn_vld,
	input  logic [7:0]  dn_id,
	input  logic [32:0] dn_key,
	input  logic [7:0]  new_id,
	input  logic [32:0] new_key,
	output logic        vld,
	output logic [7:0]  id,
	output logic [32:0] key
);
	logic        vld_q;
	logic [7:0]  id_q;
	logic [32:0] key_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (shift_up) begin
			vld_q <= up_vld;
		end else if (shift_dn) begin
			vld_q <= dn_vld;
		end
	end
	always_ff @(posedge clk) begin
		if (load) begin
			id_q <= new_id; key_q <= new_key;
		end else if (shift_up) begin
			id_q <= up_id; key_q <= up_key;
		end else if (shift_dn) begin
			id_q <= dn_id; key_q <= dn_key;
		end else if (dec) begin
			key_q <= key_q - 33'd1;
		end
	end
	assign vld = vld_q;
	assign id  = id_q;
	assign key = key_q;
endmodule

// ===== rtl/delta_list_sleep_timer.sv =====
// Delta-list sleep timer top level: command control, counters and the cell chain.
// An input transfer is executed in ST_EXEC and its result offered in ST_OUT or ST_WAKE,
// one more beat per further woken id; one item at a time, so a new command is taken only
// once the last result has transferred. Chain keeps absolute keys (sum of deltas), same wake order.
// Reset (arst_n, async low) empties the chain and reloads counters from defaults.
`timescale 1ns / 1ps
module delta_list_sleep_timer import dlst_pkg::*; #(
	parameter int NUM_PROCS = NUM_PROCS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // cmd[1:0], proc_id[9:2], delay_ms[40:10]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // status, woken_valid, woken_id, resched,
	                               // second_pulse, seconds[43:12]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int N = NUM_PROCS;

	localparam logic [1:0] ST_IDLE = 2'd0, ST_EXEC = 2'd1, ST_OUT = 2'd2, ST_WAKE = 2'd3;

	logic [1:0]  state_q;
	logic [1:0]  cmd_q;
	logic [7:0]  pid_q;
	logic [30:0] dly_q;
	logic [7:0]  quantum_q, preempt_q;
	logic [15:0] tps_q, div_q;
	logic [31:0] sec_q;
	logic        pulse_q, rs_q, st_q, wv_q;
	logic [7:0]  wid_q;
	logic [4:0]  nwake_q;

	logic [N-1:0]  vld;
	logic [7:0]    ids  [N];
	logic [32:0]   keys [N];
	logic [N-1:0]  up, dn, ld;
	logic          dec;

	// queued lookup and insert position
	logic [N-1:0] hit, gt;
	always_comb begin
		for (int i = 0; i < N; i++) begin
			hit[i] = vld[i] && ids[i] == pid_q;
			gt[i]  = !vld[i] || ($signed(keys[i]) > $signed({2'b00, dly_q}));
		end
	end
	logic queued, bad_id;
	assign queued = |hit;
	assign bad_id = {1'b0, pid_q} >= 9'(N);

	logic head_exp;
	assign head_exp = vld[0] && $signed(keys[0]) <= 33'sd0;

	logic exec_ins, exec_rem, exec_tick, wake_shift;
	assign exec_ins  = state_q == ST_EXEC && cmd_q == CMD_INSERT && dly_q != '0
	                   && !bad_id && !queued;
	assign exec_rem  = state_q == ST_EXEC && cmd_q == CMD_REMOVE && !bad_id && queued;
	assign exec_tick = state_q == ST_EXEC && cmd_q == CMD_TICK;
	assign wake_shift = state_q == ST_WAKE && m_tready && head_exp && nwake_q != 5'd0;

	// shift controls: keys are absolute, so remove and wake are a plain compaction; insert opens a gap
	always_comb begin
		logic seen;
		logic [N-1:0] lower;
		seen = 1'b0;
		for (int i = 0; i < N; i++) begin
			lower[i] = seen;
			seen = seen | (exec_rem ? hit[i] : gt[i]);
		end
		for (int i = 0; i < N; i++) begin
			up[i] = (exec_rem && (hit[i] || lower[i])) || wake_shift;
			dn[i] = exec_ins && lower[i];
			ld[i] = exec_ins && gt[i] && !lower[i];
		end
	end
	// tick subtracts one from every key
	assign dec = exec_tick;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic        uv, dv;
		logic [7:0]  ui, di;
		logic [32:0] uk, dk;
		if (i == N - 1) begin : g_top
			assign uv = 1'b0; assign ui = '0; assign uk = '0;
		end else begin : g_mid
			assign uv = vld[i+1]; assign ui = ids[i+1]; assign uk = keys[i+1];
		end
		if (i == 0) begin : g_bot
			assign dv = 1'b0; assign di = '0; assign dk = '0;
		end else begin : g_low
			assign dv = vld[i-1]; assign di = ids[i-1]; assign dk = keys[i-1];
		end
		dlst_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.shift_up(up[i]), .shift_dn(dn[i]), .load(ld[i]), .dec(dec),
			.up_vld(uv), .up_id(ui), .up_key(uk),
			.dn_vld(dv), .dn_id(di), .dn_key(dk),
			.new_id(pid_q), .new_key({2'b00, dly_q}),
			.vld(vld[i]), .id(ids[i]), .key(keys[i])
		);
	end

	assign s_tready  = state_q == ST_IDLE;
	assign cfg_ready = state_q == ST_IDLE && !s_tvalid;
	assign m_tvalid  = state_q == ST_OUT || state_q == ST_WAKE;
	assign m_tlast   = state_q == ST_OUT || !(head_exp && nwake_q > 5'd1 &&
	                   vld[1] && $signed(keys[1]) <= 33'sd0);
	assign m_tdata = {4'd0, sec_q, pulse_q, rs_q,
		state_q == ST_WAKE ? ids[0] : wid_q,
		state_q == ST_WAKE ? 1'b1 : wv_q, st_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			quantum_q <= QUANTUM_RST; tps_q <= TPS_RST;
			preempt_q <= QUANTUM_RST; div_q <= TPS_RST; sec_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_QUANTUM) quantum_q <= cfg_data[7:0];
				else tps_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: if (s_tvalid) state_q <= ST_EXEC;
				ST_EXEC: begin
					if (exec_tick) begin
						if (div_q == 16'd1) begin
							sec_q <= sec_q + 32'd1; div_q <= tps_q;
						end else div_q <= div_q - 16'd1;
						if (preempt_q <= 8'd1) preempt_q <= quantum_q;
						else preempt_q <= preempt_q - 8'd1;
						// head expires after decrement if its key is 1 or less
						state_q <= (vld[0] && $signed(keys[0]) <= 33'sd1) ? ST_WAKE : ST_OUT;
					end else state_q <= ST_OUT;
				end
				ST_OUT: if (m_tready) state_q <= ST_IDLE;
				ST_WAKE: if (m_tready && (!head_exp || nwake_q <= 5'd1 || !(vld[1] &&
					$signed(keys[1]) <= 33'sd0))) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			cmd_q <= s_tdata[1:0]; pid_q <= s_tdata[9:2]; dly_q <= s_tdata[40:10];
		end
		if (wake_shift) nwake_q <= nwake_q - 5'd1;
		if (state_q == ST_EXEC) begin
			wv_q <= 1'b0; wid_q <= '0; pulse_q <= 1'b0; nwake_q <= 5'(MAX_WAKE);
			case (cmd_q)
				CMD_TICK: begin
					st_q <= 1'b0;
					pulse_q <= div_q == 16'd1;
					rs_q <= preempt_q <= 8'd1 || (vld[0] && $signed(keys[0]) <= 33'sd1);
				end
				CMD_INSERT: begin
					if (dly_q == '0) begin st_q <= 1'b0; rs_q <= 1'b1; end
					else begin st_q <= bad_id || queued; rs_q <= !(bad_id || queued); end
				end
				CMD_REMOVE: begin st_q <= bad_id || !queued; rs_q <= 1'b0; end
				default: begin st_q <= 1'b1; rs_q <= 1'b0; end
			endcase
		end
	end
endmodule
